[sv/midi_track_event_parser_top_macros.svh]
// Assertion macros used by the parser controller.
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define MTEP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every clock outside reset.
`define MTEP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/mtep_pkg.sv]
// Shared constants and control types of the MIDI track event parser.
`timescale 1ns / 1ps
package mtep_pkg;
	localparam int TRACKS = 16;
	localparam int TIDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;

	localparam logic [3:0] PH_DELTA    = 4'd0;
	localparam logic [3:0] PH_STATUS   = 4'd1;
	localparam logic [3:0] PH_DATA1    = 4'd2;
	localparam logic [3:0] PH_DATA2    = 4'd3;
	localparam logic [3:0] PH_MTYPE    = 4'd4;
	localparam logic [3:0] PH_MLEN     = 4'd5;
	localparam logic [3:0] PH_XLEN     = 4'd6;
	localparam logic [3:0] PH_SKIP     = 4'd7;
	localparam logic [3:0] PH_DATA2_RS = 4'd8;

	localparam logic [1:0] KIND_CHAN  = 2'd0;
	localparam logic [1:0] KIND_META  = 2'd1;
	localparam logic [1:0] KIND_SYSEX = 2'd2;

	localparam logic [7:0] META_TEMPO = 8'h51;
	localparam logic [25:0] TEMPO_DIVIDEND = 26'd60000000;
	localparam logic [4:0] DIV_STEPS = 5'd26;

	typedef struct packed {
		logic accept;
		logic div_step;
	} mtep_cmd_t;

	typedef struct packed {
		logic emit;
		logic need_div;
		logic div_done;
	} mtep_sts_t;
endpackage

[sv/mtep_ctrl.sv]
// Controller: sequences accept, tempo divide and result hand-off.
`timescale 1ns / 1ps
`include "midi_track_event_parser_top_macros.svh"
module mtep_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mtep_pkg::mtep_sts_t sts,
	output mtep_pkg::mtep_cmd_t cmd
);
	import mtep_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	logic [1:0] state_q;

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = (state_q == ST_OUT);
	assign cmd.accept   = in_valid && in_ready;
	assign cmd.div_step = (state_q == ST_DIV) && !sts.div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept && sts.emit)
						state_q <= sts.need_div ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					if (sts.div_done)
						state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`MTEP_ASSERT_IMP(a_no_accept_while_out, out_valid, !in_ready, "input taken while result pending")
	`MTEP_ASSERT_NXT(a_silent_item_free, cmd.accept && !sts.emit, in_ready, "item with no result stalled")
	`MTEP_ASSERT_NXT(a_div_to_out, (state_q == ST_DIV) && sts.div_done, out_valid, "divide end gave no result")
endmodule

[sv/mtep_dp.sv]
// Datapath: per-track parse state, result register and tempo divider.
`timescale 1ns / 1ps
module mtep_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mtep_pkg::mtep_cmd_t cmd,
	output mtep_pkg::mtep_sts_t sts,
	input  logic [3:0]          track,
	input  logic [7:0]          data_byte,
	input  logic                track_start,
	output logic [1:0]          event_kind,
	output logic [7:0]          status,
	output logic [4:0]          channel,
	output logic [6:0]          data_first,
	output logic [6:0]          data_second,
	output logic signed [13:0]  pitch_bend,
	output logic [27:0]         delta_time,
	output logic [31:0]         abs_time,
	output logic [7:0]          meta_type,
	output logic [27:0]         payload_length,
	output logic [25:0]         tempo_bpm,
	output logic                used_running_status
);
	import mtep_pkg::*;

	logic [3:0]  phase_q [TRACKS];
	logic [7:0]  rs_q    [TRACKS];
	logic [7:0]  cs_q    [TRACKS];
	logic [6:0]  fd_q    [TRACKS];
	logic [27:0] acc_q   [TRACKS];
	logic [27:0] pd_q    [TRACKS];
	logic [31:0] tt_q    [TRACKS];
	logic [7:0]  pm_q    [TRACKS];
	logic [27:0] bl_q    [TRACKS];
	logic [23:0] tm_q    [TRACKS];

	logic [TIDX_W-1:0] t;
	logic trk_ok;
	logic [3:0]  n_ph;
	logic [7:0]  n_rs, n_cs, n_pm;
	logic [6:0]  n_fd, d2;
	logic [27:0] n_acc, n_pd, n_bl, acc_out, skipped;
	logic [31:0] n_tt;
	logic [23:0] n_tm;
	logic emit_ch, emit_blk, used;

	assign t      = track[TIDX_W-1:0];
	assign trk_ok = ({1'b0, track} < 5'(TRACKS));

	always_comb begin
		n_ph = phase_q[t]; n_rs = rs_q[t]; n_cs = cs_q[t]; n_fd = fd_q[t];
		n_acc = acc_q[t]; n_pd = pd_q[t]; n_tt = tt_q[t]; n_pm = pm_q[t];
		n_bl = bl_q[t]; n_tm = tm_q[t];
		d2 = 7'd0; emit_ch = 1'b0; emit_blk = 1'b0; used = 1'b0;
		acc_out = 28'd0; skipped = 28'd0;
		if (track_start) begin
			n_tt = 32'd0; n_rs = 8'd0; n_ph = PH_DELTA; n_acc = 28'd0;
		end
		case (n_ph)
			PH_STATUS: begin
				if (data_byte[7]) begin
					if (data_byte == 8'hFF) begin
						n_cs = data_byte; n_rs = 8'd0; n_ph = PH_MTYPE;
					end else if (data_byte == 8'hF0 || data_byte == 8'hF7) begin
						n_cs = data_byte; n_rs = 8'd0; n_acc = 28'd0; n_ph = PH_XLEN;
					end else if (data_byte[7:4] == 4'hF) begin
						n_ph = PH_DELTA;
					end else begin
						n_cs = data_byte; n_rs = data_byte; n_ph = PH_DATA1;
					end
				end else if (n_rs == 8'd0) begin
					n_ph = PH_DELTA;
				end else begin
					n_cs = n_rs; n_fd = data_byte[6:0];
					if (n_rs[7:4] inside {4'hC, 4'hD}) begin
						n_ph = PH_DELTA; emit_ch = 1'b1; used = 1'b1;
					end else begin
						n_ph = PH_DATA2_RS;
					end
				end
			end
			PH_DATA1: begin
				n_fd = data_byte[6:0];
				if (n_cs[7:4] inside {4'hC, 4'hD}) begin
					n_ph = PH_DELTA; emit_ch = 1'b1;
				end else begin
					n_ph = PH_DATA2;
				end
			end
			PH_DATA2, PH_DATA2_RS: begin
				used = (n_ph == PH_DATA2_RS);
				d2 = data_byte[6:0]; n_ph = PH_DELTA; emit_ch = 1'b1;
			end
			PH_MTYPE: begin
				n_pm = data_byte; n_acc = 28'd0; n_ph = PH_MLEN;
			end
			PH_MLEN, PH_XLEN: begin
				n_acc = {n_acc[20:0], data_byte[6:0]};
				if (!data_byte[7]) begin
					n_bl = n_acc; n_tm = 24'd0;
					if (n_acc != 28'd0) begin
						n_ph = PH_SKIP;
					end else begin
						n_ph = PH_DELTA; emit_blk = 1'b1; acc_out = n_acc;
					end
				end
			end
			PH_SKIP: begin
				skipped = n_acc - n_bl;
				if (n_cs == 8'hFF && n_pm == META_TEMPO && skipped < 28'd3)
					n_tm = {n_tm[15:0], data_byte};
				n_bl = n_bl - 28'd1;
				if (n_bl == 28'd0) begin
					n_ph = PH_DELTA; emit_blk = 1'b1; acc_out = n_acc; n_acc = 28'd0;
				end
			end
			default: begin
				n_acc = {n_acc[20:0], data_byte[6:0]};
				if (data_byte[7]) begin
					n_ph = PH_DELTA;
				end else begin
					n_pd = n_acc; n_tt = n_tt + {4'd0, n_acc};
					n_acc = 28'd0; n_ph = PH_STATUS;
				end
			end
		endcase
	end

	assign sts.emit     = trk_ok && (emit_ch || emit_blk);
	assign sts.need_div = emit_blk && n_cs == 8'hFF && n_pm == META_TEMPO && n_tm != 24'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKS; i++) begin
				phase_q[i] <= PH_DELTA; rs_q[i] <= 8'd0; cs_q[i] <= 8'd0;
				fd_q[i] <= 7'd0; acc_q[i] <= 28'd0; pd_q[i] <= 28'd0;
				tt_q[i] <= 32'd0; pm_q[i] <= 8'd0; bl_q[i] <= 28'd0; tm_q[i] <= 24'd0;
			end
		end else if (cmd.accept && trk_ok) begin
			phase_q[t] <= n_ph; rs_q[t] <= n_rs; cs_q[t] <= n_cs; fd_q[t] <= n_fd;
			acc_q[t] <= n_acc; pd_q[t] <= n_pd; tt_q[t] <= n_tt; pm_q[t] <= n_pm;
			bl_q[t] <= n_bl; tm_q[t] <= n_tm;
		end
	end

	// Result register
	logic bpm_sel_q;
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			event_kind          <= emit_blk ? ((n_cs == 8'hFF) ? KIND_META : KIND_SYSEX)
			                                : KIND_CHAN;
			status              <= n_cs;
			channel             <= {1'b0, n_cs[3:0]} + 5'd1;
			data_first          <= emit_blk ? 7'd0 : n_fd;
			data_second         <= d2;
			pitch_bend          <= (emit_ch && n_cs[7:4] == 4'hE)
			                       ? $signed({d2, n_fd} ^ 14'h2000) : 14'sd0;
			delta_time          <= n_pd;
			abs_time            <= n_tt;
			meta_type           <= (emit_blk && n_cs == 8'hFF) ? n_pm : 8'd0;
			payload_length      <= acc_out;
			used_running_status <= used;
			bpm_sel_q           <= sts.need_div;
		end
	end

	// Restoring divider: one quotient bit a cycle
	logic [25:0] quot_q;
	logic [23:0] rem_q, dvs_q;
	logic [4:0]  cnt_q;
	logic [24:0] rem_sh;
	logic        fits;

	assign rem_sh       = {rem_q, quot_q[25]};
	assign fits         = rem_sh >= {1'b0, dvs_q};
	assign sts.div_done = (cnt_q == DIV_STEPS);
	assign tempo_bpm    = bpm_sel_q ? quot_q : 26'd0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			quot_q <= TEMPO_DIVIDEND; rem_q <= 24'd0; dvs_q <= n_tm; cnt_q <= 5'd0;
		end else if (cmd.div_step) begin
			rem_q  <= fits ? 24'(rem_sh - {1'b0, dvs_q}) : rem_sh[23:0];
			quot_q <= {quot_q[24:0], fits};
			cnt_q  <= cnt_q + 5'd1;
		end
	end
endmodule

[sv/midi_track_event_parser_top.sv]
// Top level of the MIDI track event parser.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_ready) carries one track-chunk byte per item,
//  tagged with its track number; track_start clears that track's time,
//  running status and phase before the byte is parsed.
//  Output channel (out_valid/out_ready) carries one decoded event per item,
//  raised when a byte completes a channel message, meta or sysex event.
//  Timing: a byte with no result frees the input again in the next cycle.
//  A completing byte with no tempo divide presents its event the next cycle,
//  held until taken; the input stays closed meanwhile.
//  Set-tempo events with non-zero micros pass through the divide state
//  (26 quotient bits, one per cycle, then a finishing step) before the
//  event is shown.
//  Per-track state sits in flip-flops, all cleared by arst_n at once, so
//  bytes are taken from the first cycle after reset.
//  When the receiver stalls, hold the event and refuse further bytes.
module midi_track_event_parser_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         track,
	input  logic [7:0]         data_byte,
	input  logic               track_start,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         event_kind,
	output logic [7:0]         status,
	output logic [4:0]         channel,
	output logic [6:0]         data_first,
	output logic [6:0]         data_second,
	output logic signed [13:0] pitch_bend,
	output logic [27:0]        delta_time,
	output logic [31:0]        abs_time,
	output logic [7:0]         meta_type,
	output logic [27:0]        payload_length,
	output logic [25:0]        tempo_bpm,
	output logic               used_running_status
);
	import mtep_pkg::*;

	mtep_cmd_t cmd;
	mtep_sts_t sts;

	// Sequence accept, divide and hand-off
	mtep_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.sts, .cmd
	);

	// Parse state, result register and divider
	mtep_dp u_dp (
		.clk, .arst_n, .cmd, .sts, .track, .data_byte, .track_start,
		.event_kind, .status, .channel, .data_first, .data_second,
		.pitch_bend, .delta_time, .abs_time, .meta_type, .payload_length,
		.tempo_bpm, .used_running_status
	);
endmodule

[dv/midi_track_event_parser_top_test.sv]
// Self-checking testbench for the MIDI track event parser top level.
`timescale 1ns / 1ps
module midi_track_event_parser_top_test;
	import mtep_pkg::*;

	// Drive and capture happen at the rising edge. Inputs change through
	// nonblocking assignments, so the block sees stable values at each edge.
	// Outputs are sampled in the same way.
	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         track;
	logic [7:0]         data_byte;
	logic               track_start;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         event_kind;
	logic [7:0]         status;
	logic [4:0]         channel;
	logic [6:0]         data_first;
	logic [6:0]         data_second;
	logic signed [13:0] pitch_bend;
	logic [27:0]        delta_time;
	logic [31:0]        abs_time;
	logic [7:0]         meta_type;
	logic [27:0]        payload_length;
	logic [25:0]        tempo_bpm;
	logic               used_running_status;

	midi_track_event_parser_top dut (.*);

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  st;
		logic [4:0]  chan;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [13:0] bend;
		logic [27:0] delta;
		logic [31:0] abst;
		logic [7:0]  mtype;
		logic [27:0] plen;
		logic [25:0] bpm;
		logic        rs;
	} midi_event_t;

	typedef struct {
		logic [3:0] trk;
		logic [7:0] byte_val;
		logic       start;
		logic       check_fixed;
		midi_event_t fixed_event;
	} stim_row_t;

	// Parse state held for every track, as the block keeps it
	logic [3:0]  phase_q     [TRACKS];
	logic [7:0]  run_st_q    [TRACKS];
	logic [7:0]  cur_st_q    [TRACKS];
	logic [6:0]  first_q     [TRACKS];
	logic [27:0] accum_q     [TRACKS];
	logic [27:0] delta_q     [TRACKS];
	logic [31:0] time_q      [TRACKS];
	logic [7:0]  meta_q      [TRACKS];
	logic [27:0] left_q      [TRACKS];
	logic [23:0] micros_q    [TRACKS];

	midi_event_t expected_events[$];
	midi_event_t fixed_events[$];
	bit          fixed_flags[$];
	int          mismatch_count;
	int          events_seen;
	int          bytes_sent;
	int          idle_cycles;
	bit          hold_off;
	bit          stim_done;

	function automatic midi_event_t chan_event(int t, logic [6:0] d2, logic rs);
		midi_event_t e;
		logic [13:0] b;
		e = '0;
		e.kind  = KIND_CHAN;
		e.st    = cur_st_q[t];
		e.chan  = {1'b0, cur_st_q[t][3:0]} + 5'd1;
		e.d1    = first_q[t];
		e.d2    = d2;
		b = {d2, first_q[t]} - 14'd8192;
		e.bend  = (cur_st_q[t][7:4] == 4'hE) ? b : 14'd0;
		e.delta = delta_q[t];
		e.abst  = time_q[t];
		e.rs    = rs;
		return e;
	endfunction

	function automatic midi_event_t block_event(int t);
		midi_event_t e;
		logic is_meta;
		is_meta = (cur_st_q[t] == 8'hFF);
		e = '0;
		e.kind  = is_meta ? KIND_META : KIND_SYSEX;
		e.st    = cur_st_q[t];
		e.chan  = {1'b0, cur_st_q[t][3:0]} + 5'd1;
		e.delta = delta_q[t];
		e.abst  = time_q[t];
		e.mtype = is_meta ? meta_q[t] : 8'h00;
		e.plen  = accum_q[t];
		if (is_meta && meta_q[t] == META_TEMPO && micros_q[t] != 0)
			e.bpm = 26'(32'd60000000 / micros_q[t]);
		return e;
	endfunction

	// Advance one track's parse state by one byte; return 1 with an event if it completes
	function automatic bit parse_byte(logic [3:0] trk, logic [7:0] b, logic start,
			output midi_event_t e);
		int t;
		logic [3:0] ph;
		t = trk;
		e = '0;
		if (start) begin
			time_q[t] = 0;
			run_st_q[t] = 0;
			phase_q[t] = PH_DELTA;
			accum_q[t] = 0;
		end
		ph = phase_q[t];
		case (ph)
			PH_STATUS: begin
				if (b[7]) begin
					if (b == 8'hFF) begin
						cur_st_q[t] = b;
						run_st_q[t] = 0;
						phase_q[t] = PH_MTYPE;
					end else if (b == 8'hF0 || b == 8'hF7) begin
						cur_st_q[t] = b;
						run_st_q[t] = 0;
						accum_q[t] = 0;
						phase_q[t] = PH_XLEN;
					end else if (b >= 8'hF0) begin
						phase_q[t] = PH_DELTA;
					end else begin
						cur_st_q[t] = b;
						run_st_q[t] = b;
						phase_q[t] = PH_DATA1;
					end
					return 0;
				end
				if (run_st_q[t] == 0) begin
					phase_q[t] = PH_DELTA;
					return 0;
				end
				cur_st_q[t] = run_st_q[t];
				first_q[t] = b[6:0];
				if (cur_st_q[t][7:4] != 4'hC && cur_st_q[t][7:4] != 4'hD) begin
					phase_q[t] = PH_DATA2_RS;
					return 0;
				end
				phase_q[t] = PH_DELTA;
				e = chan_event(t, 7'd0, 1'b1);
				return 1;
			end
			PH_DATA1: begin
				first_q[t] = b[6:0];
				if (cur_st_q[t][7:4] != 4'hC && cur_st_q[t][7:4] != 4'hD) begin
					phase_q[t] = PH_DATA2;
					return 0;
				end
				phase_q[t] = PH_DELTA;
				e = chan_event(t, 7'd0, 1'b0);
				return 1;
			end
			PH_DATA2, PH_DATA2_RS: begin
				phase_q[t] = PH_DELTA;
				e = chan_event(t, b[6:0], ph == PH_DATA2_RS);
				return 1;
			end
			PH_MTYPE: begin
				meta_q[t] = b;
				accum_q[t] = 0;
				phase_q[t] = PH_MLEN;
				return 0;
			end
			PH_MLEN, PH_XLEN: begin
				accum_q[t] = {accum_q[t][20:0], b[6:0]};
				if (b[7])
					return 0;
				left_q[t] = accum_q[t];
				micros_q[t] = 0;
				if (left_q[t] != 0) begin
					phase_q[t] = PH_SKIP;
					return 0;
				end
				phase_q[t] = PH_DELTA;
				e = block_event(t);
				accum_q[t] = 0;
				return 1;
			end
			PH_SKIP: begin
				if (cur_st_q[t] == 8'hFF && meta_q[t] == META_TEMPO
						&& 28'(accum_q[t] - left_q[t]) < 28'd3)
					micros_q[t] = {micros_q[t][15:0], b};
				left_q[t] = left_q[t] - 28'd1;
				if (left_q[t] != 0)
					return 0;
				phase_q[t] = PH_DELTA;
				e = block_event(t);
				accum_q[t] = 0;
				return 1;
			end
			default: begin
				accum_q[t] = {accum_q[t][20:0], b[6:0]};
				if (b[7]) begin
					phase_q[t] = PH_DELTA;
					return 0;
				end
				delta_q[t] = accum_q[t];
				time_q[t] = time_q[t] + {4'd0, accum_q[t]};
				accum_q[t] = 0;
				phase_q[t] = PH_STATUS;
				return 0;
			end
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at event %0d: %s got 0x%0h, expected 0x%0h",
			events_seen, what, got, want);
		mismatch_count++;
	endtask

	// Clock
	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Drive one byte and hold it until the block takes it
	task automatic send_byte(logic [3:0] trk, logic [7:0] b, logic start,
			bit has_fixed, midi_event_t fixed_e);
		midi_event_t e;
		bit got;
		in_valid    <= 1'b1;
		track       <= trk;
		data_byte   <= b;
		track_start <= start;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		got = parse_byte(trk, b, start, e);
		if (got) begin
			expected_events.push_back(e);
			fixed_flags.push_back(has_fixed);
			fixed_events.push_back(fixed_e);
		end
		bytes_sent++;
	endtask

	// Random gap before the next item: mostly none or short, now and then long
	task automatic sender_gap();
		int n;
		n = $urandom_range(0, 99);
		if (n < 55)
			return;
		in_valid <= 1'b0;
		n = (n < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		repeat (n) @(posedge clk);
	endtask

	task automatic send_delta(logic [3:0] trk, int unsigned v, logic start);
		midi_event_t z;
		int k;
		logic [6:0] g[4];
		z = '0;
		for (k = 0; k < 4; k++)
			g[k] = 7'((v >> (7 * (3 - k))) & 32'h7F);
		k = 0;
		while (k < 3 && g[k] == 0)
			k++;
		for (; k < 4; k++) begin
			sender_gap();
			send_byte(trk, {k != 3, g[k]}, (k == 0) ? start : 1'b0, 0, z);
			start = 0;
		end
	endtask

	task automatic send_plain(logic [3:0] trk, logic [7:0] b);
		midi_event_t z;
		z = '0;
		sender_gap();
		send_byte(trk, b, 1'b0, 0, z);
	endtask

	// One random event on a track: well-formed with random content, mostly
	task automatic random_event(logic [3:0] trk);
		int sel;
		int len;
		int i;
		int unsigned d;
		logic [7:0] st;
		sel = $urandom_range(0, 99);
		d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
		send_delta(trk, d, $urandom_range(0, 40) == 0);
		if (sel < 55) begin
			// channel message, sometimes reusing running status
			st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
			if ($urandom_range(0, 2) != 0)
				send_plain(trk, st);
			send_plain(trk, $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 127)));
			if (st[7:4] != 4'hC && st[7:4] != 4'hD)
				send_plain(trk, 8'($urandom));
		end else if (sel < 85) begin
			// meta or sysex with a short payload; tempo often
			sel = $urandom_range(0, 3);
			send_plain(trk, sel == 0 ? 8'hF0 : (sel == 1 ? 8'hF7 : 8'hFF));
			if (sel >= 2)
				send_plain(trk, $urandom_range(0, 1) ? META_TEMPO : 8'($urandom));
			len = $urandom_range(0, 5);
			if ($urandom_range(0, 15) == 0)
				send_plain(trk, 8'h80);
			send_plain(trk, 8'(len));
			for (i = 0; i < len; i++)
				send_plain(trk, 8'($urandom));
		end else begin
			// noise
			send_plain(trk, 8'($urandom));
		end
	endtask

	// Receiver: random stalls, and one long hold-off while the sender presses on
	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				out_ready <= 1'b0;
			end else begin
				n = $urandom_range(0, 99);
				if (n < 70)
					out_ready <= 1'b1;
				else if (n < 97)
					out_ready <= 1'b0;
				else begin
					out_ready <= 1'b0;
					repeat ($urandom_range(8, 30)) @(posedge clk);
				end
			end
		end
	end

	// Compare each event taken with the oldest one predicted
	always @(posedge clk) begin
		midi_event_t w;
		midi_event_t f;
		bit has_fixed;
		if (arst_n && out_valid && out_ready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected event, status", status, 0);
			end else begin
				w = expected_events.pop_front();
				f = fixed_events.pop_front();
				has_fixed = fixed_flags.pop_front();
				if (has_fixed && f != w)
					report_mismatch("predictor versus table row", w.abst, f.abst);
				if (event_kind != w.kind)      report_mismatch("event_kind", event_kind, w.kind);
				if (status != w.st)            report_mismatch("status", status, w.st);
				if (channel != w.chan)         report_mismatch("channel", channel, w.chan);
				if (data_first != w.d1)        report_mismatch("data_first", data_first, w.d1);
				if (data_second != w.d2)       report_mismatch("data_second", data_second, w.d2);
				if (pitch_bend != w.bend)      report_mismatch("pitch_bend", pitch_bend, w.bend);
				if (delta_time != w.delta)     report_mismatch("delta_time", delta_time, w.delta);
				if (abs_time != w.abst)        report_mismatch("abs_time", abs_time, w.abst);
				if (meta_type != w.mtype)      report_mismatch("meta_type", meta_type, w.mtype);
				if (payload_length != w.plen)  report_mismatch("payload_length", payload_length, w.plen);
				if (tempo_bpm != w.bpm)        report_mismatch("tempo_bpm", tempo_bpm, w.bpm);
				if (used_running_status != w.rs)
					report_mismatch("used_running_status", used_running_status, w.rs);
			end
			events_seen++;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("midi_track_event_parser_top_test: FAIL");
			$finish;
		end
	end

	function automatic stim_row_t row(logic [3:0] trk, logic [7:0] b, logic start);
		stim_row_t r;
		r.trk = trk;
		r.byte_val = b;
		r.start = start;
		r.check_fixed = 0;
		r.fixed_event = '0;
		return r;
	endfunction

	function automatic stim_row_t row_fixed(logic [3:0] trk, logic [7:0] b,
			midi_event_t e);
		stim_row_t r;
		r = row(trk, b, 1'b0);
		r.check_fixed = 1;
		r.fixed_event = e;
		return r;
	endfunction

	// Stimulus
	initial begin
		stim_row_t   directed[$];
		midi_event_t e;
		int          i;
		int          cnt;
		logic [3:0]  trk;

		for (i = 0; i < TRACKS; i++) begin
			phase_q[i] = 0; run_st_q[i] = 0; cur_st_q[i] = 0; first_q[i] = 0;
			accum_q[i] = 0; delta_q[i] = 0; time_q[i] = 0; meta_q[i] = 0;
			left_q[i] = 0; micros_q[i] = 0;
		end
		mismatch_count = 0;
		events_seen = 0;
		bytes_sent = 0;
		hold_off = 0;
		stim_done = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		track = '0;
		data_byte = '0;
		track_start = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: note on after reset, the most negative pitch bend, running status,
		// tempo with zero, smallest and full micros, zero-length sysex, long
		// variable length, stray data and other system status.
		e = '0; e.kind = KIND_CHAN; e.st = 8'h90; e.chan = 5'd1; e.d1 = 7'd60; e.d2 = 7'd127;
		directed.push_back(row(4'd0, 8'h00, 1'b1));
		directed.push_back(row(4'd0, 8'h90, 1'b0));
		directed.push_back(row(4'd0, 8'd60, 1'b0));
		directed.push_back(row_fixed(4'd0, 8'hFF, e));      // status bit inside data
		directed.push_back(row(4'd0, 8'h00, 1'b0));
		directed.push_back(row(4'd0, 8'h3C, 1'b0));         // running status, first byte
		directed.push_back(row(4'd0, 8'h00, 1'b0));
		directed.push_back(row(4'd1, 8'h00, 1'b0));
		directed.push_back(row(4'd1, 8'hEF, 1'b0));
		directed.push_back(row(4'd1, 8'h00, 1'b0));
		e = '0; e.kind = KIND_CHAN; e.st = 8'hEF; e.chan = 5'd16; e.bend = 14'h2000;
		directed.push_back(row_fixed(4'd1, 8'h00, e));       // most negative bend
		directed.push_back(row(4'd1, 8'hFF, 1'b0));         // delta, long varlen
		for (i = 0; i < 4; i++)
			directed.push_back(row(4'd1, 8'hFF, 1'b0));
		directed.push_back(row(4'd1, 8'h7F, 1'b0));
		directed.push_back(row(4'd4, 8'h00, 1'b0));
		directed.push_back(row(4'd4, 8'h7F, 1'b0));         // stray data: dropped
		directed.push_back(row(4'd2, 8'h00, 1'b0));
		directed.push_back(row(4'd2, 8'hF5, 1'b0));         // other system: dropped
		directed.push_back(row(4'd2, 8'h00, 1'b0));
		directed.push_back(row(4'd2, 8'hF7, 1'b0));
		e = '0; e.kind = KIND_SYSEX; e.st = 8'hF7; e.chan = 5'd8;
		directed.push_back(row_fixed(4'd2, 8'h00, e));       // zero-length payload
		directed.push_back(row(4'd3, 8'h00, 1'b0));
		directed.push_back(row(4'd3, 8'hFF, 1'b0));
		directed.push_back(row(4'd3, META_TEMPO, 1'b0));
		directed.push_back(row(4'd3, 8'h01, 1'b0));
		directed.push_back(row(4'd3, 8'h01, 1'b0));         // short tempo: 60000000 bpm
		e = '0; e.kind = KIND_META; e.st = 8'hFF; e.chan = 5'd16; e.mtype = META_TEMPO;
		e.plen = 28'd3;
		directed.push_back(row(4'd3, 8'h00, 1'b0));
		directed.push_back(row(4'd3, 8'hFF, 1'b0));
		directed.push_back(row(4'd3, META_TEMPO, 1'b0));
		directed.push_back(row(4'd3, 8'h03, 1'b0));
		directed.push_back(row(4'd3, 8'h00, 1'b0));
		directed.push_back(row(4'd3, 8'h00, 1'b0));
		directed.push_back(row_fixed(4'd3, 8'h00, e));       // zero micros: no bpm
		e.bpm = 26'd3;
		directed.push_back(row(4'd3, 8'h00, 1'b0));
		directed.push_back(row(4'd3, 8'hFF, 1'b0));
		directed.push_back(row(4'd3, META_TEMPO, 1'b0));
		directed.push_back(row(4'd3, 8'h03, 1'b0));
		directed.push_back(row(4'd3, 8'hFF, 1'b0));
		directed.push_back(row(4'd3, 8'hFF, 1'b0));
		directed.push_back(row_fixed(4'd3, 8'hFF, e));       // full micros: 3 bpm
		for (i = 0; i < directed.size(); i++)
			send_byte(directed[i].trk, directed[i].byte_val, directed[i].start,
				directed[i].check_fixed, directed[i].fixed_event);

		// Random: mostly events on random tracks; one long receiver hold-off
		while (bytes_sent < 1250) begin
			trk = 4'($urandom);
			random_event(trk);
			if (bytes_sent > 600 && bytes_sent < 640 && !hold_off) begin
				hold_off = 1;
				cnt = 0;
				fork
					begin
						repeat (200) @(posedge clk);
						hold_off = 0;
					end
				join_none
			end
		end
		in_valid <= 1'b0;
		stim_done = 1;

		cnt = 0;
		while (expected_events.size() != 0 && cnt < 20000) begin
			@(posedge clk);
			cnt++;
		end
		repeat (40) @(posedge clk);
		$display("sent %0d bytes on %0d tracks, checked %0d events", bytes_sent, TRACKS,
			events_seen);
		$display("covered channel messages, running status, meta, tempo and sysex");
		if (mismatch_count == 0 && expected_events.size() == 0)
			$display("midi_track_event_parser_top_test: PASS");
		else
			$display("midi_track_event_parser_top_test: FAIL");
		$finish;
	end
endmodule

[files.f]
+incdir+sv
sv/mtep_pkg.sv
sv/mtep_ctrl.sv
sv/mtep_dp.sv
sv/midi_track_event_parser_top.sv
dv/midi_track_event_parser_top_test.sv
